// ----- hdl/ldf_pkg.sv -----
// Shared types, constants and helpers for the lidar packet deframer.
package ldf_pkg;

  localparam int unsigned LDF_QUEUE_DEPTH = 4;

  localparam logic [7:0] SYNC_BYTE1 = 8'hAA;
  localparam logic [7:0] SYNC_BYTE2 = 8'h55;
  localparam logic [15:0] SYNC_WORD = 16'h55AA;
  localparam logic [14:0] ANGLE_WRAP = 15'd23040;
  localparam logic [7:0] MAX_SAMPLES_RESET = 8'd252;

  localparam logic [1:0] RK_SAMPLE = 2'd0;
  localparam logic [1:0] RK_END = 2'd1;
  localparam logic [1:0] RK_REJECT = 2'd2;

  typedef enum logic [1:0] {
    EV_SAMPLE,
    EV_SAMPLE_END,
    EV_END,
    EV_REJECT
  } ev_kind_t;

  typedef struct packed {
    ev_kind_t    kind;
    logic [7:0]  sample_index;
    logic [15:0] distance_raw;
    logic        checksum_ok;
    logic        scan_start;
    logic [7:0]  sample_count;
    logic [15:0] first_angle_word;
    logic [15:0] last_angle_word;
  } ev_t;

  function automatic logic [14:0] angle_of(input logic [15:0] word);
    logic [14:0] a;
    a = word[15:1];
    if (a > ANGLE_WRAP) begin
      a = a - ANGLE_WRAP;
    end
    return a;
  endfunction

endpackage

// ----- hdl/ldf_front.sv -----
// Byte parser: sync hunt, header capture, sample assembly and checksum.
module ldf_front import ldf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic [7:0] max_samples,
  output logic       ev_push,
  output ev_t        ev
);

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_SYNC2,
    PH_HEADER,
    PH_SAMPLES
  } phase_t;

  phase_t      phase, phase_next;
  logic [8:0]  pos, pos_next;
  logic [7:0]  ptype, ptype_next;
  logic [7:0]  count, count_next;
  logic [15:0] fsa, fsa_next;
  logic [15:0] lsa, lsa_next;
  logic [15:0] chk, chk_next;
  logic [15:0] run_xor, run_xor_next;
  logic [7:0]  low, low_next;

  logic [15:0] word;
  logic [15:0] xor_word;
  logic [8:0]  idx_plus;

  always_comb begin
    phase_next   = phase;
    pos_next     = pos;
    ptype_next   = ptype;
    count_next   = count;
    fsa_next     = fsa;
    lsa_next     = lsa;
    chk_next     = chk;
    run_xor_next = run_xor;
    low_next     = low;
    ev_push      = 1'b0;
    ev           = '0;
    word         = {data_byte, low};
    xor_word     = run_xor ^ word;
    idx_plus     = {1'b0, pos[8:1]} + 9'd1;
    if (accept) begin
      unique case (phase)
        PH_HUNT: begin
          if (data_byte == SYNC_BYTE1) begin
            phase_next = PH_SYNC2;
          end
        end
        PH_SYNC2: begin
          pos_next = '0;
          if (data_byte == SYNC_BYTE2) begin
            phase_next   = PH_HEADER;
            run_xor_next = SYNC_WORD;
          end else begin
            phase_next = PH_HUNT;
          end
        end
        PH_HEADER: begin
          unique case (pos[2:0])
            3'd0: ptype_next = data_byte;
            3'd1: begin
              count_next   = data_byte;
              run_xor_next = run_xor ^ {data_byte, ptype};
            end
            3'd2: fsa_next = {8'h00, data_byte};
            3'd3: begin
              fsa_next     = {data_byte, fsa[7:0]};
              run_xor_next = run_xor ^ {data_byte, fsa[7:0]};
            end
            3'd4: lsa_next = {8'h00, data_byte};
            3'd5: begin
              lsa_next     = {data_byte, lsa[7:0]};
              run_xor_next = run_xor ^ {data_byte, lsa[7:0]};
            end
            3'd6: chk_next = {8'h00, data_byte};
            default: chk_next = {data_byte, chk[7:0]};
          endcase
          if (pos[2:0] == 3'd7) begin
            ev.scan_start       = ptype[0];
            ev.sample_count     = count;
            ev.first_angle_word = fsa;
            ev.last_angle_word  = lsa;
            pos_next            = '0;
            if (count > max_samples) begin
              ev_push    = 1'b1;
              ev.kind    = EV_REJECT;
              phase_next = PH_HUNT;
            end else if (count == 8'd0) begin
              ev_push        = 1'b1;
              ev.kind        = EV_END;
              ev.checksum_ok = (run_xor == {data_byte, chk[7:0]});
              phase_next     = PH_HUNT;
            end else begin
              phase_next = PH_SAMPLES;
            end
          end else begin
            pos_next = pos + 9'd1;
          end
        end
        default: begin
          if (!pos[0]) begin
            low_next = data_byte;
            pos_next = pos + 9'd1;
          end else begin
            run_xor_next        = xor_word;
            ev_push             = 1'b1;
            ev.sample_index     = pos[8:1];
            ev.distance_raw     = word;
            ev.scan_start       = ptype[0];
            ev.sample_count     = count;
            ev.first_angle_word = fsa;
            ev.last_angle_word  = lsa;
            ev.checksum_ok      = (xor_word == chk);
            if (idx_plus >= {1'b0, count}) begin
              ev.kind    = EV_SAMPLE_END;
              phase_next = PH_HUNT;
              pos_next   = '0;
            end else begin
              ev.kind  = EV_SAMPLE;
              pos_next = pos + 9'd1;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT;
      pos   <= '0;
    end else begin
      phase   <= phase_next;
      pos     <= pos_next;
      ptype   <= ptype_next;
      count   <= count_next;
      fsa     <= fsa_next;
      lsa     <= lsa_next;
      chk     <= chk_next;
      run_xor <= run_xor_next;
      low     <= low_next;
    end
  end

  a_reject_hunts: assert property (@(posedge clk) disable iff (rst)
    ev_push && ev.kind == EV_REJECT |=> phase == PH_HUNT && pos == 9'd0)
    else $error("reject did not restart hunting");

  a_push_needs_accept: assert property (@(posedge clk) disable iff (rst)
    ev_push |-> accept && (phase == PH_HEADER || phase == PH_SAMPLES))
    else $error("event pushed outside a packet");

  a_header_pos: assert property (@(posedge clk) disable iff (rst)
    phase == PH_HEADER |-> pos[8:3] == 6'd0)
    else $error("header position out of range");

endmodule

// ----- hdl/ldf_queue.sv -----
// Short event queue between the parser and the result sequencer.
module ldf_queue import ldf_pkg::*; #(
  parameter int unsigned DEPTH = LDF_QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  ev_t  din,
  output logic full,
  input  logic pop,
  output ev_t  dout,
  output logic empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

  ev_t           mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == DEPTH_CNT);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_CNT)
    else $error("queue count overflow");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    do_push && !do_pop |=> count == $past(count) + 1'b1)
    else $error("queue count lost a push");

endmodule

// ----- hdl/ldf_back.sv -----
// Result sequencer: expands queued events into result transfers.
module ldf_back import ldf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  ev_t         head,
  input  logic        q_empty,
  output logic        q_pop,
  input  logic        pop,
  output logic        empty,
  output logic [1:0]  result_kind,
  output logic [7:0]  sample_index,
  output logic [15:0] distance_raw,
  output logic        checksum_ok,
  output logic        scan_start,
  output logic [7:0]  sample_count,
  output logic [14:0] first_angle,
  output logic [14:0] last_angle,
  output logic        last
);

  logic second;
  logic first_of_two;
  logic is_sample;
  logic take;

  assign empty        = q_empty;
  assign take         = pop && !q_empty;
  assign first_of_two = (head.kind == EV_SAMPLE_END) && !second;
  assign is_sample    = (head.kind == EV_SAMPLE) || first_of_two;
  assign q_pop        = take && !first_of_two;

  always_comb begin
    last         = !first_of_two;
    sample_index = '0;
    distance_raw = '0;
    checksum_ok  = 1'b0;
    scan_start   = 1'b0;
    sample_count = '0;
    first_angle  = '0;
    last_angle   = '0;
    if (is_sample) begin
      result_kind  = RK_SAMPLE;
      sample_index = head.sample_index;
      distance_raw = head.distance_raw;
    end else begin
      result_kind  = (head.kind == EV_REJECT) ? RK_REJECT : RK_END;
      checksum_ok  = (head.kind == EV_REJECT) ? 1'b0 : head.checksum_ok;
      scan_start   = head.scan_start;
      sample_count = head.sample_count;
      first_angle  = angle_of(head.first_angle_word);
      last_angle   = angle_of(head.last_angle_word);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      second <= 1'b0;
    end else if (take) begin
      second <= first_of_two;
    end
  end

  a_split_second: assert property (@(posedge clk) disable iff (rst)
    take && first_of_two |=> second && !q_empty && head.kind == EV_SAMPLE_END)
    else $error("end result of a final sample went missing");

  a_second_only_end: assert property (@(posedge clk) disable iff (rst)
    second && !q_empty |-> head.kind == EV_SAMPLE_END)
    else $error("second half flagged on a single-result event");

endmodule

// ----- hdl/lidar_packet_deframer_core.sv -----
// Top level of the lidar packet deframer: parser, event queue, result sequencer, APB register.
//
// One received byte is taken per clock whenever the event queue has room; full rises only
// when the QUEUE_DEPTH-entry event queue between parser and result side is filled. Each byte
// gives zero or one queued event, written in the cycle the byte is taken. The byte that
// completes the last sample of a packet gives two results (sample, then packet end) that
// leave on two consecutive pops, so a result consumer popping every cycle never throttles
// the byte stream. Each result is read out of the registered event queue. max_samples is
// sampled when a header completes; it resets to 252 and is written at APB addresses 0 to 3.
module lidar_packet_deframer_core import ldf_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = LDF_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  result_kind,
  output logic [7:0]  sample_index,
  output logic [15:0] distance_raw,
  output logic        checksum_ok,
  output logic        scan_start,
  output logic [7:0]  sample_count,
  output logic [14:0] first_angle,
  output logic [14:0] last_angle,
  output logic        last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0] max_samples;
  logic       accept;
  logic       ev_push;
  ev_t        ev_in;
  ev_t        ev_head;
  logic       q_full;
  logic       q_empty;
  logic       q_pop;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {24'h000000, max_samples} : 32'h0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_samples <= MAX_SAMPLES_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      max_samples <= pwdata[7:0];
    end
  end

  assign full   = q_full;
  assign accept = push && !q_full;

  ldf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .data_byte   (data_byte),
    .max_samples (max_samples),
    .ev_push     (ev_push),
    .ev          (ev_in)
  );

  ldf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (ev_push),
    .din   (ev_in),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (ev_head),
    .empty (q_empty)
  );

  ldf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (ev_head),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .pop          (pop),
    .empty        (empty),
    .result_kind  (result_kind),
    .sample_index (sample_index),
    .distance_raw (distance_raw),
    .checksum_ok  (checksum_ok),
    .scan_start   (scan_start),
    .sample_count (sample_count),
    .first_angle  (first_angle),
    .last_angle   (last_angle),
    .last         (last)
  );

endmodule
